// ----- rtl/curvature_edge_surface_selector_top_assert.svh -----
// ----------------------------------------------------------------------------
// curvature edge/surface selector assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CURVATURE_EDGE_SURFACE_SELECTOR_TOP_ASSERT_SVH
`define CURVATURE_EDGE_SURFACE_SELECTOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CESS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CESS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CESS_ASSERT_SAME(lbl, ante, cons, msg)
`define CESS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/cess_pkg.sv -----
// ----------------------------------------------------------------------------
// cess_pkg
// shared types and constants of the curvature edge/surface selector
// ----------------------------------------------------------------------------
package cess_pkg;

    localparam int COORD_W   = 20;
    localparam int INT_W     = 16;
    localparam int CURV_W    = 50;
    localparam int GAP_W     = 42;
    localparam int LIM_W     = 4;
    localparam int PICK_W    = 5;
    localparam int CFG_W     = 50;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIM  = 2'd2;

    localparam logic [CURV_W-1:0] EDGE_THR_RST = 50'd104858;
    localparam logic [GAP_W-1:0]  GAP_THR_RST  = 42'd52429;
    localparam logic [LIM_W-1:0]  EDGE_LIM_RST = 4'd10;

    localparam logic CLASS_EDGE    = 1'b0;
    localparam logic CLASS_SURFACE = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic coord_rd;
        logic acc_en;
        logic acc_first;
        logic acc_center;
        logic sq_en;
        logic curv_wr;
        logic curv_rd;
        logic scan_en;
        logic scan_clr;
        logic scan_max;
        logic mark_best;
        logic emit_ld;
        logic emit_cls;
        logic center_ld;
        logic nb_start;
        logic nb_sq;
        logic nb_mark;
        logic flush;
        logic clr_marks;
    } cmd_t;

    typedef struct packed {
        logic best_valid;
        logic best_gt_thr;
        logic gap_gt_thr;
    } status_t;

endpackage

// ----- rtl/cess_ctrl.sv -----
// ----------------------------------------------------------------------------
// cess_ctrl
// sequencer: load, curvature, edge picking with neighbor marking, surfaces
// ----------------------------------------------------------------------------
module cess_ctrl #(
    parameter int MAX_POINTS  = 64,
    parameter int HALF_WINDOW = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  sector_last,
    output logic                                  busy,
    input  cess_pkg::status_t                     status,
    input  logic [$clog2(MAX_POINTS)-1:0]         best_idx,
    input  logic [cess_pkg::LIM_W-1:0]            edge_limit,
    output cess_pkg::cmd_t                        cmd,
    output logic [$clog2(MAX_POINTS)-1:0]         coord_addr,
    output logic [$clog2(MAX_POINTS)-1:0]         curv_addr,
    output logic [$clog2(MAX_POINTS)-1:0]         mark_addr
);
    import cess_pkg::*;

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int WIN_W    = $clog2(2 * HALF_WINDOW + 1);
    localparam int MIN_PTS  = 2 * HALF_WINDOW + 1;
    localparam int WIN_LAST = 2 * HALF_WINDOW;

    typedef enum logic [3:0] {
        S_IDLE, S_CURV_RD, S_CURV_WAIT, S_CURV_SQ, S_CURV_WR, S_SCAN, S_SCAN_WAIT,
        S_DECIDE, S_EMIT_RD, S_EMIT_LD, S_NB_RD, S_NB_SQ, S_NB_CMP, S_FLUSH, S_CLEAR
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [WIN_W-1:0]    k_reg, k_next;
    logic                surf_reg, surf_next;
    logic                down_reg, down_next;
    logic [PICK_W-1:0]   picked_reg, picked_next;
    logic [IDX_W-1:0]    nb_addr;
    logic [IDX_W-1:0]    win_addr;
    logic [CNT_W:0]      j_end;
    logic [CNT_W-1:0]    last_cand;

    assign busy      = (state_reg != S_IDLE);
    assign nb_addr   = down_reg ? (best_idx - IDX_W'(k_reg)) : (best_idx + IDX_W'(k_reg));
    assign win_addr  = j_reg - IDX_W'(HALF_WINDOW) + IDX_W'(k_reg);
    assign j_end     = (CNT_W+1)'(j_reg) + (CNT_W+1)'(HALF_WINDOW + 1);
    assign last_cand = count_reg - CNT_W'(HALF_WINDOW + 1);
    assign mark_addr = nb_addr;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        count_next  = count_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        surf_next   = surf_reg;
        down_next   = down_reg;
        picked_next = picked_reg;
        coord_addr  = win_addr;
        curv_addr   = i_reg;
        case (state_reg)
            S_IDLE:
            begin
                coord_addr = count_reg[IDX_W-1:0];
                if (start)
                begin
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        cmd.load_wr = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    if (sector_last)
                    begin
                        if (count_next < CNT_W'(MIN_PTS))
                        begin
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            j_next     = IDX_W'(HALF_WINDOW);
                            k_next     = '0;
                            state_next = S_CURV_RD;
                        end
                    end
                end
            end
            S_CURV_RD:
            begin
                cmd.coord_rd   = 1'b1;
                cmd.acc_en     = 1'b1;
                cmd.acc_first  = (k_reg == '0);
                cmd.acc_center = (k_reg == WIN_W'(HALF_WINDOW));
                if (k_reg == WIN_W'(WIN_LAST))
                begin
                    state_next = S_CURV_WAIT;
                end
                else
                begin
                    k_next = k_reg + WIN_W'(1);
                end
            end
            S_CURV_WAIT:
            begin
                state_next = S_CURV_SQ;
            end
            S_CURV_SQ:
            begin
                cmd.sq_en  = 1'b1;
                state_next = S_CURV_WR;
            end
            S_CURV_WR:
            begin
                cmd.curv_wr = 1'b1;
                curv_addr   = j_reg;
                if (j_end < {1'b0, count_reg})
                begin
                    j_next     = j_reg + IDX_W'(1);
                    k_next     = '0;
                    state_next = S_CURV_RD;
                end
                else
                begin
                    i_next       = IDX_W'(HALF_WINDOW);
                    cmd.scan_clr = 1'b1;
                    surf_next    = 1'b0;
                    picked_next  = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.curv_rd  = 1'b1;
                cmd.scan_en  = 1'b1;
                cmd.scan_max = !surf_reg;
                if (CNT_W'(i_reg) == last_cand)
                begin
                    state_next = S_SCAN_WAIT;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            S_SCAN_WAIT:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!surf_reg)
                begin
                    if (!status.best_valid || !status.best_gt_thr)
                    begin
                        i_next       = IDX_W'(HALF_WINDOW);
                        cmd.scan_clr = 1'b1;
                        surf_next    = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        cmd.mark_best = 1'b1;
                        picked_next   = picked_reg + PICK_W'(1);
                        if (picked_next > PICK_W'(edge_limit))
                        begin
                            i_next       = IDX_W'(HALF_WINDOW);
                            cmd.scan_clr = 1'b1;
                            surf_next    = 1'b1;
                            state_next   = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_EMIT_RD;
                        end
                    end
                end
                else if (!status.best_valid)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.mark_best = 1'b1;
                    state_next    = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                coord_addr   = best_idx;
                cmd.coord_rd = 1'b1;
                state_next   = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.emit_ld   = 1'b1;
                cmd.emit_cls  = surf_reg;
                cmd.center_ld = 1'b1;
                if (surf_reg)
                begin
                    i_next       = IDX_W'(HALF_WINDOW);
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    k_next     = WIN_W'(1);
                    down_next  = 1'b0;
                    state_next = S_NB_RD;
                end
            end
            S_NB_RD:
            begin
                coord_addr   = nb_addr;
                cmd.coord_rd = 1'b1;
                state_next   = S_NB_SQ;
            end
            S_NB_SQ:
            begin
                cmd.nb_sq  = 1'b1;
                state_next = S_NB_CMP;
            end
            S_NB_CMP:
            begin
                cmd.nb_mark = !status.gap_gt_thr;
                if (!status.gap_gt_thr && (k_reg != WIN_W'(HALF_WINDOW)))
                begin
                    k_next     = k_reg + WIN_W'(1);
                    state_next = S_NB_RD;
                end
                else if (!down_reg)
                begin
                    down_next    = 1'b1;
                    k_next       = WIN_W'(1);
                    cmd.nb_start = 1'b1;
                    state_next   = S_NB_RD;
                end
                else
                begin
                    i_next       = IDX_W'(HALF_WINDOW);
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.clr_marks = 1'b1;
                count_next    = '0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            j_reg      <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            surf_reg   <= 1'b0;
            down_reg   <= 1'b0;
            picked_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            j_reg      <= j_next;
            i_reg      <= i_next;
            k_reg      <= k_next;
            surf_reg   <= surf_next;
            down_reg   <= down_next;
            picked_reg <= picked_next;
        end
    end

endmodule

// ----- rtl/cess_dp.sv -----
// ----------------------------------------------------------------------------
// cess_dp
// point stores, curvature accumulator, search compare, gap check, output stage
// ----------------------------------------------------------------------------
module cess_dp #(
    parameter int MAX_POINTS  = 64,
    parameter int HALF_WINDOW = 5
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cess_pkg::cmd_t                           cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]            coord_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]            curv_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]            mark_addr,
    input  logic signed [cess_pkg::COORD_W-1:0]      point_x,
    input  logic signed [cess_pkg::COORD_W-1:0]      point_y,
    input  logic signed [cess_pkg::COORD_W-1:0]      point_z,
    input  logic [cess_pkg::INT_W-1:0]               point_intensity,
    input  logic                                     cfg_write,
    input  logic [cess_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [cess_pkg::CFG_W-1:0]               cfg_data,
    output cess_pkg::status_t                        status,
    output logic [$clog2(MAX_POINTS)-1:0]            best_idx,
    output logic [cess_pkg::LIM_W-1:0]               edge_limit,
    output logic                                     result_valid,
    output logic signed [cess_pkg::COORD_W-1:0]      out_x,
    output logic signed [cess_pkg::COORD_W-1:0]      out_y,
    output logic signed [cess_pkg::COORD_W-1:0]      out_z,
    output logic [cess_pkg::INT_W-1:0]               out_intensity,
    output logic                                     feature_class,
    output logic                                     result_last
);
    import cess_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int PT_W   = 3 * COORD_W;
    localparam int ACC_W  = COORD_W + $clog2(4 * HALF_WINDOW) + 1;
    localparam int SQ_W   = 2 * ACC_W;
    localparam int CS_W   = (SQ_W + 2 > CURV_W) ? SQ_W + 2 : CURV_W;
    localparam int DIF_W  = COORD_W + 1;
    localparam int GSQ_W  = 2 * DIF_W;
    localparam int GS_W   = GSQ_W + 2;
    localparam logic signed [ACC_W-1:0] WIN_MUL = ACC_W'(2 * HALF_WINDOW);

    logic [PT_W-1:0]    coord_mem [MAX_POINTS];
    logic [INT_W-1:0]   int_mem   [MAX_POINTS];
    logic [CURV_W-1:0]  curv_mem  [MAX_POINTS];

    logic [PT_W-1:0]    coord_rd_reg;
    logic [INT_W-1:0]   int_rd_reg;
    logic [CURV_W-1:0]  curv_rd_reg;

    logic [CURV_W-1:0]  edge_thr_reg;
    logic [GAP_W-1:0]   gap_thr_reg;
    logic [LIM_W-1:0]   edge_lim_reg;

    logic               acc_en_d_reg, acc_first_d_reg, acc_center_d_reg;
    logic               scan_en_d_reg, scan_max_d_reg;
    logic [IDX_W-1:0]   scan_idx_d_reg;

    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] term    [3];
    logic [SQ_W-1:0]         sq_reg  [3];
    logic [CS_W-1:0]         curv_full;

    logic [PT_W-1:0]    center_reg, prev_reg;
    logic [GSQ_W-1:0]   gsq_reg [3];
    logic [GS_W-1:0]    gap_sum;

    logic [MAX_POINTS-1:0] marked_reg;
    logic               best_valid_reg;
    logic [CURV_W-1:0]  best_val_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               take;

    logic               pend_valid_reg;
    logic [PT_W-1:0]    pend_pt_reg;
    logic [INT_W-1:0]   pend_int_reg;
    logic               pend_cls_reg;
    logic               res_valid_reg;
    logic [PT_W-1:0]    res_pt_reg;
    logic [INT_W-1:0]   res_int_reg;
    logic               res_cls_reg;
    logic               res_last_reg;

    // point and curvature stores
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            coord_mem[coord_addr] <= {point_x, point_y, point_z};
            int_mem[coord_addr]   <= point_intensity;
        end
        if (cmd.coord_rd)
        begin
            coord_rd_reg <= coord_mem[coord_addr];
            int_rd_reg   <= int_mem[coord_addr];
        end
        if (cmd.curv_wr)
        begin
            curv_mem[curv_addr] <= curv_full[CURV_W-1:0];
        end
        if (cmd.curv_rd)
        begin
            curv_rd_reg <= curv_mem[curv_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_thr_reg <= EDGE_THR_RST;
            gap_thr_reg  <= GAP_THR_RST;
            edge_lim_reg <= EDGE_LIM_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_EDGE_THR: edge_thr_reg <= cfg_data[CURV_W-1:0];
                REG_GAP_THR:  gap_thr_reg  <= cfg_data[GAP_W-1:0];
                REG_EDGE_LIM: edge_lim_reg <= cfg_data[LIM_W-1:0];
                default:      edge_lim_reg <= edge_lim_reg;
            endcase
        end
    end

    assign edge_limit = edge_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_d_reg     <= 1'b0;
            acc_first_d_reg  <= 1'b0;
            acc_center_d_reg <= 1'b0;
            scan_en_d_reg    <= 1'b0;
            scan_max_d_reg   <= 1'b0;
        end
        else
        begin
            acc_en_d_reg     <= cmd.acc_en;
            acc_first_d_reg  <= cmd.acc_first;
            acc_center_d_reg <= cmd.acc_center;
            scan_en_d_reg    <= cmd.scan_en;
            scan_max_d_reg   <= cmd.scan_max;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_d_reg <= curv_addr;
    end

    // window accumulation and squaring
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            term[c] = ACC_W'($signed(coord_rd_reg[PT_W-1-c*COORD_W -: COORD_W]));
            if (acc_center_d_reg)
            begin
                term[c] = -(WIN_MUL * term[c]);
            end
        end
    end

    assign curv_full = CS_W'(sq_reg[0]) + CS_W'(sq_reg[1]) + CS_W'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (acc_en_d_reg)
            begin
                acc_reg[c] <= acc_first_d_reg ? term[c] : acc_reg[c] + term[c];
            end
            if (cmd.sq_en)
            begin
                sq_reg[c] <= SQ_W'(acc_reg[c] * acc_reg[c]);
            end
        end
    end

    // neighbor gap
    always_ff @(posedge clk)
    begin
        if (cmd.center_ld)
        begin
            center_reg <= coord_rd_reg;
            prev_reg   <= coord_rd_reg;
        end
        else if (cmd.nb_start)
        begin
            prev_reg <= center_reg;
        end
        else if (cmd.nb_mark)
        begin
            prev_reg <= coord_rd_reg;
        end
        if (cmd.nb_sq)
        begin
            for (int c = 0; c < 3; c++)
            begin
                gsq_reg[c] <= GSQ_W'(
                    (DIF_W'($signed(coord_rd_reg[PT_W-1-c*COORD_W -: COORD_W]))
                     - DIF_W'($signed(prev_reg[PT_W-1-c*COORD_W -: COORD_W])))
                    * (DIF_W'($signed(coord_rd_reg[PT_W-1-c*COORD_W -: COORD_W]))
                     - DIF_W'($signed(prev_reg[PT_W-1-c*COORD_W -: COORD_W]))));
            end
        end
    end

    assign gap_sum = GS_W'(gsq_reg[0]) + GS_W'(gsq_reg[1]) + GS_W'(gsq_reg[2]);

    // best candidate search
    assign take = scan_en_d_reg && !marked_reg[scan_idx_d_reg]
                  && (!best_valid_reg
                      || (scan_max_d_reg ? (curv_rd_reg >= best_val_reg)
                                         : (curv_rd_reg < best_val_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            marked_reg     <= '0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.clr_marks)
            begin
                marked_reg <= '0;
            end
            else if (cmd.mark_best)
            begin
                marked_reg[best_idx_reg] <= 1'b1;
            end
            else if (cmd.nb_mark)
            begin
                marked_reg[mark_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_val_reg <= curv_rd_reg;
            best_idx_reg <= scan_idx_d_reg;
        end
    end

    assign best_idx           = best_idx_reg;
    assign status.best_valid  = best_valid_reg;
    assign status.best_gt_thr = (best_val_reg > edge_thr_reg);
    assign status.gap_gt_thr  = (gap_sum > GS_W'(gap_thr_reg));

    // one-deep hold so the final transaction can carry result_last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= (cmd.emit_ld || cmd.flush) && pend_valid_reg;
            if (cmd.emit_ld)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld || cmd.flush)
        begin
            res_pt_reg   <= pend_pt_reg;
            res_int_reg  <= pend_int_reg;
            res_cls_reg  <= pend_cls_reg;
            res_last_reg <= cmd.flush;
        end
        if (cmd.emit_ld)
        begin
            pend_pt_reg  <= coord_rd_reg;
            pend_int_reg <= int_rd_reg;
            pend_cls_reg <= cmd.emit_cls;
        end
    end

    assign result_valid  = res_valid_reg;
    assign out_x         = res_pt_reg[PT_W-1 -: COORD_W];
    assign out_y         = res_pt_reg[PT_W-1-COORD_W -: COORD_W];
    assign out_z         = res_pt_reg[COORD_W-1:0];
    assign out_intensity = res_int_reg;
    assign feature_class = res_cls_reg;
    assign result_last   = res_last_reg;

endmodule

// ----- rtl/curvature_edge_surface_selector_top.sv -----
// ----------------------------------------------------------------------------
// curvature_edge_surface_selector_top
// Points load at one per cycle while busy is low. The point with sector_last
// raises busy; the block then computes the curvature of each candidate,
// runs one search through the curvature store per edge pick and per surface
// point, emits each point through a read step and a load step, marks up to
// HALF_WINDOW neighbors on each side of each emitted edge, ends with one more
// search that finds nothing, and drops busy the cycle after the last result.
// The steps run one after another, as the point and curvature stores each
// have a single read port. Results leave one per result_valid pulse and the
// receiver cannot stall them; result_last marks the final one of the sector.
// ----------------------------------------------------------------------------
module curvature_edge_surface_selector_top #(
    parameter int MAX_POINTS  = 64,
    parameter int HALF_WINDOW = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [cess_pkg::COORD_W-1:0]  point_x,
    input  logic signed [cess_pkg::COORD_W-1:0]  point_y,
    input  logic signed [cess_pkg::COORD_W-1:0]  point_z,
    input  logic [cess_pkg::INT_W-1:0]           point_intensity,
    input  logic                                 sector_last,
    input  logic                                 cfg_write,
    input  logic [cess_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cess_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 result_valid,
    output logic signed [cess_pkg::COORD_W-1:0]  out_x,
    output logic signed [cess_pkg::COORD_W-1:0]  out_y,
    output logic signed [cess_pkg::COORD_W-1:0]  out_z,
    output logic [cess_pkg::INT_W-1:0]           out_intensity,
    output logic                                 feature_class,
    output logic                                 result_last
);
    import cess_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    cmd_t               cmd;
    status_t            status;
    logic [IDX_W-1:0]   best_idx;
    logic [IDX_W-1:0]   coord_addr;
    logic [IDX_W-1:0]   curv_addr;
    logic [IDX_W-1:0]   mark_addr;
    logic [LIM_W-1:0]   edge_limit;

    cess_ctrl #(
        .MAX_POINTS  (MAX_POINTS),
        .HALF_WINDOW (HALF_WINDOW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .sector_last (sector_last),
        .busy        (busy),
        .status      (status),
        .best_idx    (best_idx),
        .edge_limit  (edge_limit),
        .cmd         (cmd),
        .coord_addr  (coord_addr),
        .curv_addr   (curv_addr),
        .mark_addr   (mark_addr)
    );

    cess_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .HALF_WINDOW (HALF_WINDOW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .coord_addr      (coord_addr),
        .curv_addr       (curv_addr),
        .mark_addr       (mark_addr),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .point_intensity (point_intensity),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .status          (status),
        .best_idx        (best_idx),
        .edge_limit      (edge_limit),
        .result_valid    (result_valid),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .out_intensity   (out_intensity),
        .feature_class   (feature_class),
        .result_last     (result_last)
    );

`include "curvature_edge_surface_selector_top_assert.svh"

    `CESS_ASSERT_SAME(a_result_only_busy, result_valid, busy, "result transaction while idle")
    `CESS_ASSERT_NEXT(a_last_ends_sector, result_valid && result_last, !result_valid, "result after last")
    `CESS_ASSERT_NEXT(a_last_point_busy, start && !busy && sector_last, busy, "no selection after last point")

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// curvature edge/surface selector testbench
// loads lidar sectors into the block, predicts the edge and surface points
// of each sector, and checks every emitted point in order against the
// prediction across several register settings and idle patterns
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cess_pkg::*;

    localparam int DEPTH      = 64;
    localparam int HALF       = 5;
    localparam int STALL_MAX  = 40000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [INT_W-1:0]   inten;
        logic               cls;
        logic               last;
    } feature_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [COORD_W-1:0]  point_x = '0;
    logic signed [COORD_W-1:0]  point_y = '0;
    logic signed [COORD_W-1:0]  point_z = '0;
    logic [INT_W-1:0]           point_intensity = '0;
    logic                       sector_last = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       result_valid;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic [INT_W-1:0]           out_intensity;
    logic                       feature_class;
    logic                       result_last;

    // predictor state
    logic [CURV_W-1:0]  edge_thr = EDGE_THR_RST;
    logic [GAP_W-1:0]   gap_thr = GAP_THR_RST;
    logic [LIM_W-1:0]   edge_lim = EDGE_LIM_RST;
    logic signed [COORD_W-1:0] pts[DEPTH][3];
    logic [INT_W-1:0]   pts_int[DEPTH];
    int                 pts_count = 0;

    feature_t           feature_queue[$];
    int                 mismatch_count = 0;
    int                 stall_cycles = 0;
    int                 idle_pct = 0;
    int                 points_sent = 0;

    curvature_edge_surface_selector_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .point_intensity(point_intensity),
        .sector_last    (sector_last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .out_intensity  (out_intensity),
        .feature_class  (feature_class),
        .result_last    (result_last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic longint unsigned gap_between(input int a, input int b);
        longint unsigned s;
        longint d;
        s = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = longint'(pts[a][c]) - longint'(pts[b][c]);
            s += longint'(d * d);
        end
        return s;
    endfunction

    function automatic feature_t make_feature(input int idx, input logic cls);
        feature_t f;
        f.x = pts[idx][0];
        f.y = pts[idx][1];
        f.z = pts[idx][2];
        f.inten = pts_int[idx];
        f.cls = cls;
        f.last = 1'b0;
        return f;
    endfunction

    // selection over the stored sector, queueing expected points in order
    task automatic select_features();
        logic [CURV_W-1:0] curv[DEPTH];
        logic              marked[DEPTH];
        int                order[DEPTH];
        int                m;
        int                p;
        int                picked;
        int                produced;
        int                c;
        longint            d;
        longint unsigned   cv;
        m = 0;
        picked = 0;
        produced = 0;
        for (int j = 0; j < DEPTH; j++)
            marked[j] = 1'b0;
        if (pts_count < 2 * HALF + 1)
            return;
        for (int j = HALF; j + HALF < pts_count; j++)
        begin
            cv = 0;
            for (int a = 0; a < 3; a++)
            begin
                d = -longint'(2 * HALF) * longint'(pts[j][a]);
                for (int k = 1; k <= HALF; k++)
                    d += longint'(pts[j-k][a]) + longint'(pts[j+k][a]);
                cv += longint'(d * d);
            end
            curv[j] = cv[CURV_W-1:0];
            p = m;
            while (p > 0 && (curv[j] < curv[order[p-1]] ||
                   (curv[j] == curv[order[p-1]] && j < order[p-1])))
            begin
                order[p] = order[p-1];
                p--;
            end
            order[p] = j;
            m++;
        end
        for (int i = m - 1; i >= 0; i--)
        begin
            c = order[i];
            if (marked[c])
                continue;
            if (curv[c] <= edge_thr)
                break;
            picked++;
            marked[c] = 1'b1;
            if (picked > edge_lim)
                break;
            feature_queue = {feature_queue, make_feature(c, CLASS_EDGE)};
            produced++;
            for (int k = 1; k <= HALF; k++)
            begin
                if (gap_between(c + k, c + k - 1) > gap_thr)
                    break;
                marked[c+k] = 1'b1;
            end
            for (int k = 1; k <= HALF; k++)
            begin
                if (gap_between(c - k, c - k + 1) > gap_thr)
                    break;
                marked[c-k] = 1'b1;
            end
        end
        for (int j = 0; j < m; j++)
        begin
            if (!marked[order[j]])
            begin
                feature_queue = {feature_queue, make_feature(order[j], CLASS_SURFACE)};
                produced++;
            end
        end
        if (produced > 0)
            feature_queue[$].last = 1'b1;
    endtask

    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input logic [INT_W-1:0] inten,
                              input logic last);
        start <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        point_intensity <= inten;
        sector_last <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        points_sent++;
        if (pts_count < DEPTH)
        begin
            pts[pts_count][0] = x;
            pts[pts_count][1] = y;
            pts[pts_count][2] = z;
            pts_int[pts_count] = inten;
            pts_count++;
        end
        if (last)
        begin
            select_features();
            pts_count = 0;
        end
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (feature_queue.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_EDGE_THR: edge_thr = val[CURV_W-1:0];
            REG_GAP_THR:  gap_thr = val[GAP_W-1:0];
            REG_EDGE_LIM: edge_lim = val[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CURV_W-1:0] thr, input logic [GAP_W-1:0] gap,
                             input logic [LIM_W-1:0] lim);
        wait_idle();
        write_reg(REG_EDGE_THR, CFG_W'(thr));
        write_reg(REG_GAP_THR, CFG_W'(gap));
        write_reg(REG_EDGE_LIM, CFG_W'(lim));
    endtask

    // smooth scan line with random spikes, or pure noise
    task automatic send_sector(input int n, input bit noisy);
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] bz;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] sz;
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        for (int i = 0; i < n; i++)
        begin
            bx += COORD_W'($urandom_range(0, 80)) - 20'd40;
            by += COORD_W'($urandom_range(0, 80)) - 20'd40;
            bz += COORD_W'($urandom_range(0, 20)) - 20'd10;
            sx = bx;
            sy = by;
            sz = bz;
            if (noisy)
            begin
                sx = $urandom;
                sy = $urandom;
                sz = $urandom;
            end
            else if ($urandom_range(5) == 0)
            begin
                sx += COORD_W'($urandom_range(0, 8000)) - 20'd4000;
                sz += COORD_W'($urandom_range(0, 2000)) - 20'd1000;
            end
            send_point(sx, sy, sz, INT_W'($urandom), i == n - 1);
        end
    endtask

    task automatic run_random(input int count);
        int n;
        int target;
        target = points_sent + count;
        while (points_sent < target)
        begin
            case ($urandom_range(9))
                0: n = $urandom_range(1, 10);
                1: n = $urandom_range(60, 70);
                default: n = $urandom_range(11, 24);
            endcase
            if (n > target - points_sent)
                n = target - points_sent;
            send_sector(n, $urandom_range(4) == 0);
        end
    endtask

    task automatic test_short_sector();
        for (int i = 0; i < 5; i++)
            send_point(20'(i * 100), 20'd0, 20'd0, 16'(i), i == 4);
    endtask

    task automatic test_extremes();
        for (int i = 0; i < 11; i++)
        begin
            if (i % 2 == 0)
                send_point(20'h7FFFF, 20'h80000, 20'h7FFFF, 16'hFFFF, i == 10);
            else
                send_point(20'h80000, 20'h7FFFF, 20'h80000, 16'h0000, i == 10);
        end
    endtask

    task automatic test_ties();
        for (int i = 0; i < 11; i++)
            send_point(20'(i * 3), 20'hFFFFF, 20'd7, 16'(i + 1), i == 10);
    endtask

    task automatic test_register_extremes();
        configure(50'd0, 42'd0, 4'd0);
        run_random(36);
        configure({CURV_W{1'b1}}, {GAP_W{1'b1}}, 4'd15);
        run_random(27);
        configure(50'd0, {GAP_W{1'b1}}, 4'd15);
        run_random(36);
        configure(50'd1000, 42'd0, 4'd15);
        run_random(27);
    endtask

    task automatic test_idle_patterns();
        configure(EDGE_THR_RST, GAP_THR_RST, EDGE_LIM_RST);
        idle_pct = 71;
        run_random(45);
        idle_pct = 0;
        run_random(36);
        idle_pct = 13;
        run_random(36);
    endtask

    always @(posedge clk)
    begin
        feature_t exp_f;
        if (rst_n && result_valid)
        begin
            if (feature_queue.size() == 0)
                report_mismatch("result with no expected point");
            else
            begin
                exp_f = feature_queue.pop_front();
                if (out_x !== exp_f.x || out_y !== exp_f.y || out_z !== exp_f.z)
                    report_mismatch($sformatf("coords %h %h %h expected %h %h %h",
                        out_x, out_y, out_z, exp_f.x, exp_f.y, exp_f.z));
                if (out_intensity !== exp_f.inten)
                    report_mismatch($sformatf("intensity %h expected %h",
                        out_intensity, exp_f.inten));
                if (feature_class !== exp_f.cls)
                    report_mismatch($sformatf("class %b expected %b",
                        feature_class, exp_f.cls));
                if (result_last !== exp_f.last)
                    report_mismatch($sformatf("last %b expected %b",
                        result_last, exp_f.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        configure(EDGE_THR_RST, GAP_THR_RST, EDGE_LIM_RST);
        test_short_sector();
        test_extremes();
        test_ties();
        test_register_extremes();
        test_idle_patterns();
        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
